### hdl/byte_vm_execute_unit_top_assert.svh
// Assertion macros for the byte VM execute unit checker
`ifndef BYTE_VM_EXECUTE_UNIT_TOP_ASSERT_SVH
`define BYTE_VM_EXECUTE_UNIT_TOP_ASSERT_SVH
// plain property, sampled on clock, off during reset
`define BVM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// implication, sampled on clock, off during reset
`define BVM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`endif

### hdl/bvm_pkg.sv
// Types, codes and sizes shared by the byte VM execute unit
package bvm_pkg;
   localparam int BVM_NUM_REGS    = 16;
   localparam int BVM_DATA_WORDS  = 256;
   localparam int BVM_STACK_DEPTH = 64;

   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,  OP_SUB = 5'd1,  OP_LDI = 5'd2,  OP_STR = 5'd3,
      OP_LDM  = 5'd4,  OP_LDA = 5'd5,  OP_STA = 5'd6,  OP_PUSH = 5'd7,
      OP_POP  = 5'd8,  OP_INC = 5'd9,  OP_DEC = 5'd10, OP_AND = 5'd11,
      OP_OR   = 5'd12, OP_XOR = 5'd13, OP_NOT = 5'd14, OP_MUL = 5'd15,
      OP_DIV  = 5'd16, OP_MOD = 5'd17, OP_JMP = 5'd18, OP_JZ = 5'd19,
      OP_JNZ  = 5'd20, OP_JE  = 5'd21, OP_JNE = 5'd22, OP_JG = 5'd23,
      OP_JGE  = 5'd24, OP_JL  = 5'd25, OP_JLE = 5'd26
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_BAD_MEM = 3'd1,
      ST_OVERFLOW = 3'd2,
      ST_UNDERFLOW = 3'd3,
      ST_DIV_ZERO = 3'd4,
      ST_BAD_JUMP = 3'd5
   } status_type;

   localparam logic [8:0] PLEN_RESET = 9'd256;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic mem_rd;
      logic div_start;
      logic div_step;
      logic commit;
   } bvm_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_div;
      logic div_done;
   } bvm_sts_type;
endpackage

### hdl/bvm_if.sv
// Channel interfaces: decoded instruction in, execution result out
interface bvm_req_if;
   logic       valid;
   logic       ready;
   logic [4:0] op;
   logic [7:0] operand_a;
   logic [7:0] operand_b;
   logic [7:0] operand_c;
   modport source (output valid, op, operand_a, operand_b, operand_c, input ready);
   modport sink (input valid, op, operand_a, operand_b, operand_c, output ready);
endinterface

interface bvm_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] next_ip;
   logic [7:0] written_value;
   logic       reg_write;
   logic       mem_write;
   modport source (output valid, status, next_ip, written_value, reg_write, mem_write,
                   input ready);
   modport sink (input valid, status, next_ip, written_value, reg_write, mem_write,
                 output ready);
endinterface

### hdl/byte_vm_execute_unit_top.sv
// Byte VM execute unit: executes one decoded instruction per item
// Usage:
//   req_bus carries one decoded instruction (op and three operand bytes);
//   an item is taken when valid and ready are both high.
//   rsp_bus returns one result per item: status, next_ip, written_value,
//   reg_write and mem_write, held in an output register until taken.
//   csr_wr_en/csr_wr_data write program_length; write only while idle.
// Sequence:
//   Items are processed one at a time: accept, operand fetch with
//   memory/stack read, execute. Div and mod with a nonzero divisor add a
//   divide state before execute, which runs the 8-step bit-serial divider
//   and its done check. The register file reads are registered at accept,
//   the data memory or stack read in operand fetch; execute then writes
//   the output register.
//   A new item is accepted while the previous result still waits in the
//   output register; execute holds if that register has not been taken.
// Reset:
//   Registers and data memory read as zero, stack empty, ip zero,
//   program_length 256. No clearing pass: per-entry valid bits are cleared.
module byte_vm_execute_unit_top import bvm_pkg::*; #(
   parameter int NUM_REGS    = BVM_NUM_REGS,
   parameter int DATA_WORDS  = BVM_DATA_WORDS,
   parameter int STACK_DEPTH = BVM_STACK_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   bvm_req_if.sink    req_bus,
   bvm_rsp_if.source  rsp_bus,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data
);
   bvm_cmd_type cmd;
   bvm_sts_type sts;

   bvm_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req_bus.valid), .req_ready(req_bus.ready),
      .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready),
      .cmd, .sts);

   bvm_dp #(.NUM_REGS(NUM_REGS), .DATA_WORDS(DATA_WORDS), .STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock, .reset, .cmd, .sts,
      .in_op(req_bus.op), .in_a(req_bus.operand_a), .in_b(req_bus.operand_b),
      .in_c(req_bus.operand_c),
      .csr_wr_en, .csr_wr_data,
      .out_status(rsp_bus.status), .out_next_ip(rsp_bus.next_ip),
      .out_written_value(rsp_bus.written_value),
      .out_reg_write(rsp_bus.reg_write), .out_mem_write(rsp_bus.mem_write));
endmodule

### hdl/bvm_ram.sv
// Generic single-write, single-read RAM with registered read data
module bvm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### hdl/bvm_dp.sv
// Datapath: register file, data memory, stack, divider, pointers, result register
module bvm_dp import bvm_pkg::*; #(
   parameter int NUM_REGS    = BVM_NUM_REGS,
   parameter int DATA_WORDS  = BVM_DATA_WORDS,
   parameter int STACK_DEPTH = BVM_STACK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  bvm_cmd_type cmd,
   output bvm_sts_type sts,
   input  logic [4:0]  in_op,
   input  logic [7:0]  in_a,
   input  logic [7:0]  in_b,
   input  logic [7:0]  in_c,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data,
   output logic [2:0]  out_status,
   output logic [7:0]  out_next_ip,
   output logic [7:0]  out_written_value,
   output logic        out_reg_write,
   output logic        out_mem_write
);
   localparam int RIDX = $clog2(NUM_REGS);
   localparam int DIDX = $clog2(DATA_WORDS);
   localparam int SIDX = $clog2(STACK_DEPTH);
   localparam int CW   = $clog2(STACK_DEPTH + 1);
   localparam logic [8:0]  NREG9  = 9'(NUM_REGS);
   localparam logic [8:0]  NDATA9 = 9'(DATA_WORDS);
   localparam logic [CW-1:0] SDEPTH = CW'(STACK_DEPTH);

   // item and control state
   logic [4:0]    op_ff;
   logic [7:0]    a_ff, b_ff, c_ff;
   logic          avld_ff, bvld_ff, dvld_ff;
   logic [7:0]    ip_ff, ip_in;
   logic [8:0]    plen_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NUM_REGS-1:0]   rvalid_ff;
   logic [DATA_WORDS-1:0] dvalid_ff;

   // divider
   logic [7:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [3:0] dcnt_ff, dcnt_in;
   logic [8:0] trial;

   // result register
   logic [2:0] st_ff;
   logic [7:0] nip_ff, wv_ff;
   logic       rw_ff, mw_ff;

   logic [7:0] ra_rd, rb_rd, dm_rd, sk_rd;
   logic [7:0] ra, rb, mdata;
   logic [7:0] maddr_rd;

   // computed result
   status_type status;
   logic [7:0] val;
   logic       dreg_en, maddr_en, push, pop, take;
   logic [7:0] dreg, maddr, tgt;
   logic       do_reg, do_mem, do_push, ok;
   logic [7:0] next_ip;

   assign ra    = avld_ff ? ra_rd : 8'd0;
   assign rb    = bvld_ff ? rb_rd : 8'd0;
   assign mdata = dvld_ff ? dm_rd : 8'd0;
   assign maddr_rd = (op_type'(op_ff) == OP_LDM) ? b_ff : ra;

   bvm_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_rf_a (
      .clock, .wr_en(do_reg), .wr_addr(dreg[RIDX-1:0]), .wr_data(val),
      .rd_en(cmd.capture), .rd_addr(in_a[RIDX-1:0]), .rd_data(ra_rd));
   bvm_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_rf_b (
      .clock, .wr_en(do_reg), .wr_addr(dreg[RIDX-1:0]), .wr_data(val),
      .rd_en(cmd.capture), .rd_addr(in_b[RIDX-1:0]), .rd_data(rb_rd));
   bvm_ram #(.WIDTH(8), .DEPTH(DATA_WORDS)) u_dmem (
      .clock, .wr_en(do_mem), .wr_addr(maddr[DIDX-1:0]), .wr_data(val),
      .rd_en(cmd.mem_rd), .rd_addr(maddr_rd[DIDX-1:0]), .rd_data(dm_rd));
   bvm_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
      .clock, .wr_en(do_push), .wr_addr(cnt_ff[SIDX-1:0]), .wr_data(val),
      .rd_en(cmd.mem_rd), .rd_addr(SIDX'(cnt_ff - CW'(1))), .rd_data(sk_rd));

   // one quotient bit per step, restoring
   always_comb begin
      trial  = {rem_ff, quo_ff[7]} - {1'b0, rb};
      rem_in = rem_ff;
      quo_in = quo_ff;
      dcnt_in = dcnt_ff;
      if (cmd.div_start) begin
         rem_in  = 8'd0;
         quo_in  = ra;
         dcnt_in = 4'd0;
      end else if (cmd.div_step) begin
         if (!trial[8]) begin
            rem_in = trial[7:0];
            quo_in = {quo_ff[6:0], 1'b1};
         end else begin
            rem_in = {rem_ff[6:0], quo_ff[7]};
            quo_in = {quo_ff[6:0], 1'b0};
         end
         dcnt_in = dcnt_ff + 4'd1;
      end
   end

   assign sts.need_div = ((op_type'(op_ff) == OP_DIV) || (op_type'(op_ff) == OP_MOD))
                         && (rb != 8'd0);
   assign sts.div_done = dcnt_ff[3];

   always_comb begin
      status   = ST_OK;
      val      = 8'd0;
      dreg_en  = 1'b0;
      dreg     = c_ff;
      maddr_en = 1'b0;
      maddr    = b_ff;
      push     = 1'b0;
      pop      = 1'b0;
      take     = 1'b0;
      tgt      = c_ff;
      unique case (op_type'(op_ff))
         OP_ADD: begin dreg_en = 1'b1; val = ra + rb; end
         OP_SUB: begin dreg_en = 1'b1; val = ra - rb; end
         OP_LDI: begin dreg_en = 1'b1; dreg = a_ff; val = b_ff; end
         OP_STR: begin
            if ({1'b0, b_ff} < NDATA9) begin maddr_en = 1'b1; val = ra; end
            else status = ST_BAD_MEM;
         end
         OP_LDM: begin
            if ({1'b0, b_ff} < NDATA9) begin dreg_en = 1'b1; dreg = a_ff; val = mdata; end
            else status = ST_BAD_MEM;
         end
         OP_LDA: begin
            if ({1'b0, ra} < NDATA9) begin dreg_en = 1'b1; dreg = b_ff; val = mdata; end
            else status = ST_BAD_MEM;
         end
         OP_STA: begin
            if ({1'b0, ra} < NDATA9) begin maddr_en = 1'b1; maddr = ra; val = rb; end
            else status = ST_BAD_MEM;
         end
         OP_PUSH: begin
            if (cnt_ff < SDEPTH) begin push = 1'b1; val = ra; end
            else status = ST_OVERFLOW;
         end
         OP_POP: begin
            if (cnt_ff != '0) begin
               pop = 1'b1; dreg_en = 1'b1; dreg = a_ff; val = sk_rd;
            end else status = ST_UNDERFLOW;
         end
         OP_INC: begin dreg_en = 1'b1; dreg = a_ff; val = ra + 8'd1; end
         OP_DEC: begin dreg_en = 1'b1; dreg = a_ff; val = ra - 8'd1; end
         OP_AND: begin dreg_en = 1'b1; val = ra & rb; end
         OP_OR:  begin dreg_en = 1'b1; val = ra | rb; end
         OP_XOR: begin dreg_en = 1'b1; val = ra ^ rb; end
         OP_NOT: begin dreg_en = 1'b1; dreg = b_ff; val = ~ra; end
         OP_MUL: begin dreg_en = 1'b1; val = 8'(16'(ra) * 16'(rb)); end
         OP_DIV: begin
            if (rb != 8'd0) begin dreg_en = 1'b1; val = quo_ff; end
            else status = ST_DIV_ZERO;
         end
         OP_MOD: begin
            if (rb != 8'd0) begin dreg_en = 1'b1; val = rem_ff; end
            else status = ST_DIV_ZERO;
         end
         OP_JMP: begin take = 1'b1; tgt = a_ff; end
         OP_JZ:  begin take = (ra == 8'd0); tgt = b_ff; end
         OP_JNZ: begin take = (ra != 8'd0); tgt = b_ff; end
         OP_JE:  take = (ra == rb);
         OP_JNE: take = (ra != rb);
         OP_JG:  take = ($signed(ra) >  $signed(rb));
         OP_JGE: take = ($signed(ra) >= $signed(rb));
         OP_JL:  take = ($signed(ra) <  $signed(rb));
         OP_JLE: take = ($signed(ra) <= $signed(rb));
         default: ;
      endcase
      if (status == ST_OK && take && ({1'b0, tgt} >= plen_ff)) begin
         status = ST_BAD_JUMP;
      end
   end

   assign ok      = (status == ST_OK);
   assign do_reg  = cmd.commit && ok && dreg_en && ({1'b0, dreg} < NREG9);
   assign do_mem  = cmd.commit && ok && maddr_en;
   assign do_push = cmd.commit && ok && push;
   assign next_ip = !ok ? ip_ff : (take ? tgt : ip_ff + 8'd1);

   always_comb begin
      ip_in  = ip_ff;
      cnt_in = cnt_ff;
      if (cmd.commit) begin
         ip_in = next_ip;
         if (ok && pop)  cnt_in = cnt_ff - CW'(1);
         if (ok && push) cnt_in = cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_ff     <= 8'd0;
         plen_ff   <= PLEN_RESET;
         cnt_ff    <= '0;
         rvalid_ff <= '0;
         dvalid_ff <= '0;
         dcnt_ff   <= 4'd0;
      end else begin
         ip_ff   <= ip_in;
         cnt_ff  <= cnt_in;
         dcnt_ff <= dcnt_in;
         if (csr_wr_en) plen_ff <= csr_wr_data;
         if (do_reg) rvalid_ff[dreg[RIDX-1:0]] <= 1'b1;
         if (do_mem) dvalid_ff[maddr[DIDX-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.capture) begin
         op_ff   <= in_op;
         a_ff    <= in_a;
         b_ff    <= in_b;
         c_ff    <= in_c;
         avld_ff <= ({1'b0, in_a} < NREG9) && rvalid_ff[in_a[RIDX-1:0]];
         bvld_ff <= ({1'b0, in_b} < NREG9) && rvalid_ff[in_b[RIDX-1:0]];
      end
      if (cmd.mem_rd) begin
         dvld_ff <= ({1'b0, maddr_rd} < NDATA9) && dvalid_ff[maddr_rd[DIDX-1:0]];
      end
      if (cmd.commit) begin
         st_ff  <= status;
         nip_ff <= next_ip;
         rw_ff  <= do_reg;
         mw_ff  <= do_mem || do_push;
         wv_ff  <= (do_reg || do_mem || do_push) ? val : 8'd0;
      end
   end

   assign out_status        = st_ff;
   assign out_next_ip       = nip_ff;
   assign out_written_value = wv_ff;
   assign out_reg_write     = rw_ff;
   assign out_mem_write     = mw_ff;
endmodule

### hdl/bvm_ctrl.sv
// Controller: sequences fetch, memory read, divide and commit for one item
module bvm_ctrl import bvm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output bvm_cmd_type cmd,
   input  bvm_sts_type sts
);
   typedef enum logic [1:0] {S_IDLE, S_OPS, S_DIV, S_EXEC} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_OPS;
            end
         end
         S_OPS: begin
            cmd.mem_rd = 1'b1;
            if (sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_EXEC;
            else cmd.div_step = 1'b1;
         end
         S_EXEC: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

### hdl/bvm_checker.sv
// Port-level checker for the byte VM execute unit, bound to the top level
`include "byte_vm_execute_unit_top_assert.svh"
module bvm_checker import bvm_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] status,
   input logic [7:0] written_value,
   input logic       reg_write,
   input logic       mem_write
);
   `BVM_ASSERT_IMP(a_rsp_hold, $past(rsp_valid && !rsp_ready) && !$past(reset), rsp_valid, "result dropped before taken")
   `BVM_ASSERT_IMP(a_one_at_a_time, $past(req_valid && req_ready) && !$past(reset), !req_ready, "second item taken during execution")
   `BVM_ASSERT_IMP(a_err_no_write, rsp_valid && status != ST_OK, !reg_write && !mem_write && written_value == 8'd0, "error result reports a write")
   `BVM_ASSERT(a_status_range, !rsp_valid || status <= ST_BAD_JUMP, "status code out of range")
endmodule

bind byte_vm_execute_unit_top bvm_checker u_bvm_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_bus.valid), .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready),
   .status(rsp_bus.status), .written_value(rsp_bus.written_value),
   .reg_write(rsp_bus.reg_write), .mem_write(rsp_bus.mem_write));
